// ----- rtl/i2cme_pkg.sv -----
// Package for the I2C master message engine: phase, byte-kind, function and
// status codes, mode flag positions, address constants and the result item type.
// No dependencies.
`default_nettype none
package i2cme_pkg;

  typedef enum logic [4:0] {
    PH_IDLE, PH_WAITDESC, PH_BEGIN, PH_LOAD, PH_BYTEDONE, PH_DATA, PH_DATDAT,
    PH_MSGDONE, PH_FINISH, PH_S1, PH_RS0, PH_RS1, PH_RS2, PH_RS3,
    PH_SP0, PH_SP1, PH_SP2, PH_SP3, PH_TX0, PH_TX1, PH_TX2,
    PH_AK0, PH_AK1, PH_AK2, PH_RX0, PH_RX1, PH_RX2, PH_MA0, PH_MA1, PH_MA2
  } phase_e;

  typedef enum logic [2:0] {
    K_A1, K_A2, K_A3, K_CTL, K_DAT
  } kind_e;

  typedef enum logic [1:0] {
    FN_DESC  = 2'd0,
    FN_WRITE = 2'd1,
    FN_TICK  = 2'd2,
    FN_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ADDR_NAK = 2'd1,
    ST_DATA_NAK = 2'd2
  } status_e;

  localparam int unsigned FL_RD      = 0;
  localparam int unsigned FL_TEN     = 1;
  localparam int unsigned FL_NOSTART = 2;
  localparam int unsigned FL_NOSTOP  = 3;
  localparam int unsigned FL_IGN     = 4;
  localparam int unsigned FL_NORACK  = 5;
  localparam int unsigned FL_FILL    = 6;
  localparam int unsigned FL_CTL     = 7;

  localparam logic [7:0] TEN_HDR  = 8'hf0;
  localparam logic [7:0] TEN_MASK = 8'h06;

  localparam int unsigned CHAIN_STEPS = 7;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       done;
    logic [1:0] status;
    logic [7:0] msgs;
    logic [7:0] bytes;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/i2cme_fifo.sv -----
// Write byte queue for the I2C message engine: circular buffer with count.
// Depends on nothing but its parameter.
`default_nettype none
module i2cme_fifo #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire logic [7:0] data_i,
  input  wire logic       pop_i,
  input  wire logic       clear_i,
  output logic [7:0]      head_o,
  output logic            empty_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [7:0]    mem_q [DEPTH];
  logic [PW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          full, do_push;

  assign full    = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    rd_d  = rd_q;
    wr_d  = wr_q;
    cnt_d = cnt_q;
    if (clear_i) begin
      rd_d  = '0;
      wr_d  = '0;
      cnt_d = '0;
    end else if (do_push) begin
      wr_d  = (wr_q == LAST) ? '0 : wr_q + 1'b1;
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !empty_o) begin
      rd_d  = (rd_q == LAST) ? '0 : rd_q + 1'b1;
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push && !clear_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/i2cme_core.sv -----
// Message sequencer of the I2C engine: descriptor, counters, shift register,
// bus phase state machine. Uses i2cme_pkg; the write queue sits outside.
`default_nettype none
module i2cme_core
  import i2cme_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       take_i,
  input  wire logic [1:0] func_i,
  input  wire logic       sda_in_i,
  input  wire logic [9:0] addr_i,
  input  wire logic [7:0] flags_i,
  input  wire logic [7:0] len_i,
  input  wire logic [7:0] ctl_i,
  input  wire logic [7:0] fill_i,
  input  wire logic       last_i,
  input  wire logic [2:0] retry_limit_i,
  input  wire logic [7:0] fifo_head_i,
  input  wire logic       fifo_empty_i,
  output logic            fifo_pop_o,
  output logic            fifo_clear_o,
  output result_t         res_o
);
  phase_e     phase_q, phase_d;
  kind_e      kind_q, kind_d;
  logic [3:0] bit_q, bit_d;
  logic [7:0] sh_q, sh_d, byte_q, byte_d, msg_q, msg_d;
  logic [2:0] retry_q, retry_d;
  logic [1:0] fail_q, fail_d;
  logic       ack_q, ack_d, stopf_q, stopf_d, scl_q, scl_d, sda_q, sda_d;
  logic [9:0] daddr_q, daddr_d;
  logic [7:0] dflags_q, dflags_d, dlen_q, dlen_d, dctl_q, dctl_d, dfill_q, dfill_d;
  logic       dlast_q, dlast_d;

  always_comb begin : step
    logic       consumed, done, rxv, ign;
    logic [7:0] rxd;
    logic [2:0] tries;
    phase_d = phase_q; kind_d = kind_q; bit_d = bit_q; sh_d = sh_q;
    byte_d = byte_q; msg_d = msg_q; retry_d = retry_q; fail_d = fail_q;
    ack_d = ack_q; stopf_d = stopf_q; scl_d = scl_q; sda_d = sda_q;
    daddr_d = daddr_q; dflags_d = dflags_q; dlen_d = dlen_q; dctl_d = dctl_q;
    dfill_d = dfill_q; dlast_d = dlast_q;
    consumed = 1'b0; done = 1'b0; rxv = 1'b0; rxd = '0;
    ign = dflags_q[FL_IGN];
    tries = ign ? 3'd0 : retry_limit_i;
    fifo_pop_o = 1'b0;
    if (take_i && func_i == FN_DESC &&
        (phase_q == PH_IDLE || phase_q == PH_WAITDESC)) begin
      if (phase_q == PH_IDLE) begin
        msg_d  = '0;
        fail_d = ST_OK;
      end
      daddr_d = addr_i; dflags_d = flags_i; dlen_d = len_i; dctl_d = ctl_i;
      dfill_d = fill_i; dlast_d = last_i;
      byte_d = '0; retry_d = '0;
      phase_d = PH_BEGIN;
    end
    if (take_i && func_i == FN_TICK) begin
      for (int unsigned i = 0; i < CHAIN_STEPS; i++) begin
        if (!consumed) begin
          case (phase_d)
            PH_BEGIN: begin
              retry_d = '0;
              if (dflags_q[FL_NOSTART]) begin
                phase_d = PH_DATA;
              end else begin
                kind_d  = K_A1;
                phase_d = (msg_d == '0 && scl_d && sda_d) ? PH_S1 : PH_RS0;
              end
            end
            PH_LOAD: begin
              case (kind_d)
                K_A2:    sh_d = daddr_q[7:0];
                K_A3:    sh_d = TEN_HDR | ({5'd0, daddr_q[9:8], 1'b0} & TEN_MASK) | 8'h01;
                default: begin
                  if (dflags_q[FL_TEN]) begin
                    sh_d = TEN_HDR | ({5'd0, daddr_q[9:8], 1'b0} & TEN_MASK);
                  end else begin
                    sh_d = {daddr_q[6:0], dflags_q[FL_RD]};
                  end
                end
              endcase
              bit_d = '0; phase_d = PH_TX0;
            end
            PH_BYTEDONE: begin
              if (kind_d == K_A1 || kind_d == K_A3) begin
                if (!ack_d && retry_d < tries) begin
                  retry_d = retry_d + 3'd1; stopf_d = 1'b0; phase_d = PH_SP0;
                end else if (!ack_d && !ign) begin
                  fail_d = ST_ADDR_NAK; phase_d = PH_FINISH;
                end else if (kind_d == K_A1 && dflags_q[FL_TEN]) begin
                  kind_d = K_A2; phase_d = PH_LOAD;
                end else begin
                  phase_d = PH_DATA;
                end
              end else if (kind_d == K_A2) begin
                if (!ack_d && !ign) begin
                  fail_d = ST_ADDR_NAK; phase_d = PH_FINISH;
                end else if (dflags_q[FL_RD]) begin
                  kind_d = K_A3; retry_d = '0; phase_d = PH_RS0;
                end else begin
                  phase_d = PH_DATA;
                end
              end else if (kind_d == K_CTL) begin
                if (!ack_d) begin
                  fail_d = ST_DATA_NAK; phase_d = PH_FINISH;
                end else begin
                  phase_d = PH_DATDAT;
                end
              end else begin
                if (!ack_d && !ign) begin
                  fail_d = ST_DATA_NAK; phase_d = PH_FINISH;
                end else begin
                  byte_d = byte_d + 8'd1; phase_d = PH_DATA;
                end
              end
            end
            PH_DATA: begin
              if (byte_d >= dlen_q) begin
                phase_d = PH_MSGDONE;
              end else if (dflags_q[FL_RD]) begin
                sh_d = '0; bit_d = '0; phase_d = PH_RX0;
              end else if (dflags_q[FL_CTL]) begin
                kind_d = K_CTL; sh_d = dctl_q; bit_d = '0; phase_d = PH_TX0;
              end else begin
                phase_d = PH_DATDAT;
              end
            end
            PH_DATDAT: begin
              if (!dflags_q[FL_FILL] && fifo_empty_i) begin
                consumed = 1'b1;
              end else begin
                if (dflags_q[FL_FILL]) begin
                  sh_d = dfill_q;
                end else begin
                  sh_d = fifo_head_i; fifo_pop_o = 1'b1;
                end
                kind_d = K_DAT; bit_d = '0; phase_d = PH_TX0;
              end
            end
            PH_MSGDONE: begin
              msg_d = msg_d + 8'd1;
              if (dlast_q) begin
                phase_d = PH_FINISH;
              end else begin
                phase_d = PH_WAITDESC; consumed = 1'b1;
              end
            end
            PH_FINISH: begin
              if (dflags_q[FL_NOSTOP]) begin
                done = 1'b1; consumed = 1'b1;
              end else begin
                stopf_d = 1'b1; phase_d = PH_SP0;
              end
            end
            PH_S1: begin scl_d = 1'b1; sda_d = 1'b0; phase_d = PH_LOAD; consumed = 1'b1; end
            PH_RS0: begin scl_d = 1'b0; phase_d = PH_RS1; consumed = 1'b1; end
            PH_SP0: begin scl_d = 1'b0; phase_d = PH_SP1; consumed = 1'b1; end
            PH_TX0: begin scl_d = 1'b0; phase_d = PH_TX1; consumed = 1'b1; end
            PH_AK0: begin scl_d = 1'b0; phase_d = PH_AK1; consumed = 1'b1; end
            PH_RX0: begin scl_d = 1'b0; phase_d = PH_RX1; consumed = 1'b1; end
            PH_MA0: begin scl_d = 1'b0; phase_d = PH_MA1; consumed = 1'b1; end
            PH_RS1: begin scl_d = 1'b0; sda_d = 1'b1; phase_d = PH_RS2; consumed = 1'b1; end
            PH_RS2: begin scl_d = 1'b1; sda_d = 1'b1; phase_d = PH_RS3; consumed = 1'b1; end
            PH_RS3: begin scl_d = 1'b1; sda_d = 1'b0; phase_d = PH_LOAD; consumed = 1'b1; end
            PH_SP1: begin scl_d = 1'b0; sda_d = 1'b0; phase_d = PH_SP2; consumed = 1'b1; end
            PH_SP2: begin scl_d = 1'b1; sda_d = 1'b0; phase_d = PH_SP3; consumed = 1'b1; end
            PH_SP3: begin
              scl_d = 1'b1; sda_d = 1'b1; consumed = 1'b1;
              if (stopf_d) done = 1'b1;
              else phase_d = PH_S1;
            end
            PH_TX1: begin scl_d = 1'b0; sda_d = sh_d[7]; phase_d = PH_TX2; consumed = 1'b1; end
            PH_TX2: begin
              scl_d = 1'b1; consumed = 1'b1;
              sh_d = {sh_d[6:0], 1'b0};
              bit_d = bit_d + 4'd1;
              phase_d = (bit_d >= 4'd8) ? PH_AK0 : PH_TX0;
            end
            PH_AK1: begin scl_d = 1'b0; sda_d = 1'b1; phase_d = PH_AK2; consumed = 1'b1; end
            PH_AK2: begin
              scl_d = 1'b1; sda_d = 1'b1; ack_d = !sda_in_i;
              phase_d = PH_BYTEDONE; consumed = 1'b1;
            end
            PH_RX1: begin scl_d = 1'b0; sda_d = 1'b1; phase_d = PH_RX2; consumed = 1'b1; end
            PH_RX2: begin
              scl_d = 1'b1; sda_d = 1'b1; consumed = 1'b1;
              sh_d = {sh_d[6:0], sda_in_i};
              bit_d = bit_d + 4'd1;
              if (bit_d >= 4'd8) begin
                rxv = 1'b1; rxd = sh_d; byte_d = byte_d + 8'd1;
                phase_d = dflags_q[FL_NORACK] ? PH_DATA : PH_MA0;
              end else begin
                phase_d = PH_RX0;
              end
            end
            PH_MA1: begin
              scl_d = 1'b0; sda_d = (byte_d < dlen_q) ? 1'b0 : 1'b1;
              phase_d = PH_MA2; consumed = 1'b1;
            end
            PH_MA2: begin scl_d = 1'b1; phase_d = PH_DATA; consumed = 1'b1; end
            default: consumed = 1'b1;
          endcase
        end
      end
    end
    res_o.scl      = scl_d;
    res_o.sda      = sda_d;
    res_o.rx_valid = rxv;
    res_o.rx_data  = rxd;
    res_o.done     = done;
    res_o.status   = done ? fail_d : ST_OK;
    res_o.msgs     = (done && fail_d != ST_OK) ? 8'd0 : msg_d;
    res_o.bytes    = byte_d;
    fifo_clear_o   = done;
    if (done) begin
      phase_d = PH_IDLE; msg_d = '0; fail_d = ST_OK; retry_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; kind_q <= K_A1; bit_q <= '0; sh_q <= '0;
      byte_q <= '0; msg_q <= '0; retry_q <= '0; fail_q <= ST_OK;
      ack_q <= 1'b0; stopf_q <= 1'b0; scl_q <= 1'b1; sda_q <= 1'b1;
      daddr_q <= '0; dflags_q <= '0; dlen_q <= '0; dctl_q <= '0;
      dfill_q <= '0; dlast_q <= 1'b0;
    end else begin
      phase_q <= phase_d; kind_q <= kind_d; bit_q <= bit_d; sh_q <= sh_d;
      byte_q <= byte_d; msg_q <= msg_d; retry_q <= retry_d; fail_q <= fail_d;
      ack_q <= ack_d; stopf_q <= stopf_d; scl_q <= scl_d; sda_q <= sda_d;
      daddr_q <= daddr_d; dflags_q <= dflags_d; dlen_q <= dlen_d; dctl_q <= dctl_d;
      dfill_q <= dfill_d; dlast_q <= dlast_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/i2c_master_message_engine.sv -----
// I2C master message engine. Each item (descriptor, write byte or bus tick) is
// taken on a handshake; a tick yields one result item in the output register in
// the next cycle, and a new item is taken each cycle while that register is empty or
// being drained. The phase sequencer settles the internal steps of a tick
// combinationally. Uses i2cme_pkg, i2cme_core, i2cme_fifo.
`default_nettype none
module i2c_master_message_engine
  import i2cme_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // sda_in, target_address, mode_flags, message_length, control_byte,
  // fill_byte, data_byte, zero pad
  input  wire logic [55:0] s_axis_tdata,
  // func
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // scl_out, sda_out, rx_valid, rx_data, status, messages_done, bytes_done,
  // zero pad
  output logic [31:0]      m_axis_tdata,
  output logic             m_axis_tlast
);
  logic [2:0] limit_q;
  logic       take, pop, clear, empty;
  logic [7:0] head;
  result_t    res, res_q;
  logic       ovld_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {29'd0, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 3'd3;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      limit_q <= pwdata[2:0];
    end
  end

  assign s_axis_tready = !ovld_q || m_axis_tready;
  assign take = s_axis_tvalid && s_axis_tready;

  i2cme_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take && s_axis_tuser == FN_WRITE),
    .data_i  (s_axis_tdata[50:43]),
    .pop_i   (pop),
    .clear_i (clear),
    .head_o  (head),
    .empty_o (empty)
  );

  i2cme_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .func_i        (s_axis_tuser),
    .sda_in_i      (s_axis_tdata[0]),
    .addr_i        (s_axis_tdata[10:1]),
    .flags_i       (s_axis_tdata[18:11]),
    .len_i         (s_axis_tdata[26:19]),
    .ctl_i         (s_axis_tdata[34:27]),
    .fill_i        (s_axis_tdata[42:35]),
    .last_i        (s_axis_tlast),
    .retry_limit_i (limit_q),
    .fifo_head_i   (head),
    .fifo_empty_i  (empty),
    .fifo_pop_o    (pop),
    .fifo_clear_o  (clear),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (take) begin
      ovld_q <= (s_axis_tuser == FN_TICK);
    end else if (m_axis_tready) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && s_axis_tuser == FN_TICK) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tlast  = res_q.done;
  assign m_axis_tdata  = {3'd0, res_q.bytes, res_q.msgs, res_q.status, res_q.rx_data,
                          res_q.rx_valid, res_q.sda, res_q.scl};

endmodule
`default_nettype wire

// ----- rtl/i2cme_checker.sv -----
// Port-level checks for the I2C message engine result stream.
// Bound to i2c_master_message_engine; sees its ports only.
`default_nettype none
module i2cme_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item dropped while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[12:11] == 2'd0)
    else $error("status off the done item");

  a_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[10:3] == 8'd0)
    else $error("rx data without rx valid");

  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[12:11] != 2'd0 |-> m_axis_tdata[20:13] == 8'd0)
    else $error("message count on failed transfer");

  a_done_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && m_axis_tdata[12:11] != 2'd0 |-> m_axis_tdata[0])
    else $error("scl low on failed done item");
endmodule

bind i2c_master_message_engine i2cme_checker u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// ----- tb/sv/tb_i2c_master_message_engine.sv -----
// Testbench for the I2C master message engine: drives descriptors, write bytes
// and bus ticks, predicts each tick's result item and checks it field by field.
// Depends on i2cme_pkg and the i2c_master_message_engine RTL.
module tb_i2c_master_message_engine;
  import i2cme_pkg::*;

  class i2c_scoreboard;
    bit [2:0]   retry_limit;
    phase_e     ph;
    kind_e      kd;
    bit [3:0]   bit_cnt;
    bit [7:0]   shreg, byte_cnt, msg_cnt;
    bit [2:0]   retry_cnt;
    bit [9:0]   d_addr;
    bit [7:0]   d_flags, d_len, d_ctl, d_fill;
    bit         d_last, acked, stop_final, scl, sda;
    bit [1:0]   fail_st;
    bit [7:0]   fifo [16];
    int         rd_ptr, fifo_cnt;
    result_t    expected_q[$];
    int         errors;

    function new();
      retry_limit = 3; ph = PH_IDLE; kd = K_A1; bit_cnt = 0; shreg = 0; byte_cnt = 0;
      msg_cnt = 0; retry_cnt = 0; d_addr = 0; d_flags = 0; d_len = 0; d_ctl = 0;
      d_fill = 0; d_last = 0; acked = 0; stop_final = 0; scl = 1; sda = 1;
      fail_st = ST_OK; rd_ptr = 0; fifo_cnt = 0; errors = 0;
    endfunction

    function bit [7:0] addr_byte();
      if (kd == K_A2) return d_addr[7:0];
      if (kd == K_A3) return TEN_HDR | ({5'd0, d_addr[9:8], 1'b0} & TEN_MASK) | 8'h01;
      if (d_flags[FL_TEN]) return TEN_HDR | ({5'd0, d_addr[9:8], 1'b0} & TEN_MASK);
      return {d_addr[6:0], d_flags[FL_RD]};
    endfunction

    function void fail(bit [1:0] s);
      fail_st = s; ph = PH_FINISH;
    endfunction

    function void byte_done();
      bit ign;
      bit [2:0] tries;
      ign = d_flags[FL_IGN];
      tries = ign ? 3'd0 : retry_limit;
      if (kd == K_A1 || kd == K_A3) begin
        if (!acked && retry_cnt < tries) begin
          retry_cnt++; stop_final = 0; ph = PH_SP0;
        end else if (!acked && !ign) fail(ST_ADDR_NAK);
        else if (kd == K_A1 && d_flags[FL_TEN]) begin
          kd = K_A2; ph = PH_LOAD;
        end else ph = PH_DATA;
      end else if (kd == K_A2) begin
        if (!acked && !ign) fail(ST_ADDR_NAK);
        else if (d_flags[FL_RD]) begin
          kd = K_A3; retry_cnt = 0; ph = PH_RS0;
        end else ph = PH_DATA;
      end else if (kd == K_CTL) begin
        if (!acked) fail(ST_DATA_NAK);
        else ph = PH_DATDAT;
      end else begin
        if (!acked && !ign) fail(ST_DATA_NAK);
        else begin
          byte_cnt++; ph = PH_DATA;
        end
      end
    endfunction

    function result_t bus_tick(bit sda_in);
      result_t r;
      bit held, done, rxv;
      bit [7:0] rxd;
      held = 0; done = 0; rxv = 0; rxd = 0;
      for (int g = 0; g < 12 && !held; g++) begin
        case (ph)
          PH_BEGIN: begin
            retry_cnt = 0;
            if (d_flags[FL_NOSTART]) ph = PH_DATA;
            else begin
              kd = K_A1;
              ph = (msg_cnt == 0 && scl && sda) ? PH_S1 : PH_RS0;
            end
          end
          PH_LOAD: begin
            shreg = addr_byte(); bit_cnt = 0; ph = PH_TX0;
          end
          PH_BYTEDONE: byte_done();
          PH_DATA: begin
            if (byte_cnt >= d_len) ph = PH_MSGDONE;
            else if (d_flags[FL_RD]) begin
              shreg = 0; bit_cnt = 0; ph = PH_RX0;
            end else if (d_flags[FL_CTL]) begin
              kd = K_CTL; shreg = d_ctl; bit_cnt = 0; ph = PH_TX0;
            end else ph = PH_DATDAT;
          end
          PH_DATDAT: begin
            if (!d_flags[FL_FILL] && fifo_cnt == 0) held = 1;
            else begin
              if (d_flags[FL_FILL]) shreg = d_fill;
              else begin
                shreg = fifo[rd_ptr];
                rd_ptr = (rd_ptr + 1) % 16;
                fifo_cnt--;
              end
              kd = K_DAT; bit_cnt = 0; ph = PH_TX0;
            end
          end
          PH_MSGDONE: begin
            msg_cnt++;
            if (d_last) ph = PH_FINISH;
            else begin
              ph = PH_WAITDESC; held = 1;
            end
          end
          PH_FINISH: begin
            if (d_flags[FL_NOSTOP]) begin
              done = 1; held = 1;
            end else begin
              stop_final = 1; ph = PH_SP0;
            end
          end
          PH_S1: begin
            scl = 1; sda = 0; ph = PH_LOAD; held = 1;
          end
          PH_RS0, PH_SP0, PH_TX0, PH_AK0, PH_RX0, PH_MA0: begin
            scl = 0; ph = phase_e'(ph + 1); held = 1;
          end
          PH_RS1: begin
            scl = 0; sda = 1; ph = PH_RS2; held = 1;
          end
          PH_RS2: begin
            scl = 1; sda = 1; ph = PH_RS3; held = 1;
          end
          PH_RS3: begin
            scl = 1; sda = 0; ph = PH_LOAD; held = 1;
          end
          PH_SP1: begin
            scl = 0; sda = 0; ph = PH_SP2; held = 1;
          end
          PH_SP2: begin
            scl = 1; sda = 0; ph = PH_SP3; held = 1;
          end
          PH_SP3: begin
            scl = 1; sda = 1; held = 1;
            if (stop_final) done = 1;
            else ph = PH_S1;
          end
          PH_TX1: begin
            scl = 0; sda = shreg[7]; ph = PH_TX2; held = 1;
          end
          PH_TX2: begin
            scl = 1; held = 1; shreg = shreg << 1; bit_cnt++;
            ph = (bit_cnt >= 8) ? PH_AK0 : PH_TX0;
          end
          PH_AK1: begin
            scl = 0; sda = 1; ph = PH_AK2; held = 1;
          end
          PH_AK2: begin
            scl = 1; sda = 1; acked = !sda_in; ph = PH_BYTEDONE; held = 1;
          end
          PH_RX1: begin
            scl = 0; sda = 1; ph = PH_RX2; held = 1;
          end
          PH_RX2: begin
            scl = 1; sda = 1; held = 1;
            shreg = {shreg[6:0], sda_in}; bit_cnt++;
            if (bit_cnt >= 8) begin
              rxv = 1; rxd = shreg; byte_cnt++;
              ph = d_flags[FL_NORACK] ? PH_DATA : PH_MA0;
            end else ph = PH_RX0;
          end
          PH_MA1: begin
            scl = 0; sda = (byte_cnt < d_len) ? 1'b0 : 1'b1; ph = PH_MA2; held = 1;
          end
          PH_MA2: begin
            scl = 1; ph = PH_DATA; held = 1;
          end
          default: held = 1;
        endcase
      end
      r.scl = scl; r.sda = sda; r.rx_valid = rxv; r.rx_data = rxd; r.done = done;
      r.status = ST_OK; r.msgs = msg_cnt; r.bytes = byte_cnt;
      if (done) begin
        r.status = fail_st;
        if (fail_st != ST_OK) r.msgs = 0;
        ph = PH_IDLE; msg_cnt = 0; fail_st = ST_OK; retry_cnt = 0;
        rd_ptr = 0; fifo_cnt = 0;
      end
      return r;
    endfunction

    function void note_input(func_e fn, logic [55:0] d, logic last);
      case (fn)
        FN_DESC: if (ph == PH_IDLE || ph == PH_WAITDESC) begin
          if (ph == PH_IDLE) begin
            msg_cnt = 0; fail_st = ST_OK;
          end
          d_addr = d[10:1]; d_flags = d[18:11]; d_len = d[26:19];
          d_ctl = d[34:27]; d_fill = d[42:35]; d_last = last;
          byte_cnt = 0; retry_cnt = 0; ph = PH_BEGIN;
        end
        FN_WRITE: if (fifo_cnt < 16) begin
          fifo[(rd_ptr + fifo_cnt) % 16] = d[50:43];
          fifo_cnt++;
        end
        FN_TICK: expected_q.push_back(bus_tick(d[0]));
        default: ;
      endcase
    endfunction

    function void check_result(result_t act);
      result_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result item %h", $time, act);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (act.scl !== exp.scl || act.sda !== exp.sda || act.rx_valid !== exp.rx_valid ||
          act.rx_data !== exp.rx_data || act.done !== exp.done ||
          act.status !== exp.status || act.msgs !== exp.msgs || act.bytes !== exp.bytes) begin
        $display("%0t: mismatch expected scl %b sda %b rxv %b rxd %h done %b st %0d msgs %0d bytes %0d",
                 $time, exp.scl, exp.sda, exp.rx_valid, exp.rx_data, exp.done, exp.status,
                 exp.msgs, exp.bytes);
        $display("%0t:          actual   scl %b sda %b rxv %b rxd %h done %b st %0d msgs %0d bytes %0d",
                 $time, act.scl, act.sda, act.rx_valid, act.rx_data, act.done, act.status,
                 act.msgs, act.bytes);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0, rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic        pready;
  logic        s_axis_tvalid = 0, s_axis_tready, s_axis_tlast = 0;
  logic [55:0] s_axis_tdata = 0;
  logic [1:0]  s_axis_tuser = 0;
  logic        m_axis_tvalid, m_axis_tready = 0, m_axis_tlast;
  logic [31:0] m_axis_tdata;

  i2c_scoreboard sb = new();
  int items_sent = 0;
  int gap_max = 14, stall_max = 14;
  int nack_pct = 5;

  i2c_master_message_engine u_top (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  always @(posedge clk_i) begin
    result_t r;
    if (m_axis_tvalid && m_axis_tready) begin
      r.scl = m_axis_tdata[0]; r.sda = m_axis_tdata[1]; r.rx_valid = m_axis_tdata[2];
      r.rx_data = m_axis_tdata[10:3]; r.status = m_axis_tdata[12:11];
      r.msgs = m_axis_tdata[20:13]; r.bytes = m_axis_tdata[28:21]; r.done = m_axis_tlast;
      sb.check_result(r);
    end
    if (s_axis_tvalid && s_axis_tready)
      sb.note_input(func_e'(s_axis_tuser), s_axis_tdata, s_axis_tlast);
  end

  int stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
      if (m_axis_tvalid && m_axis_tready && stall_max > 0)
        stall_left <= $urandom_range(0, stall_max);
    end
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic send(func_e fn, logic [9:0] addr, logic [7:0] flags, logic [7:0] len,
                      logic [7:0] ctl, logic [7:0] fill, logic [7:0] dbyte, logic last,
                      logic sda_in);
    int gap;
    gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid <= 0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tuser  <= fn;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {5'd0, dbyte, fill, ctl, len, flags, addr, sda_in};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    items_sent++;
  endtask

  task automatic send_tick();
    send(FN_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         ($urandom_range(0, 99) < nack_pct));
  endtask

  task automatic send_byte(logic [7:0] b);
    send(FN_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom, b, $urandom, $urandom);
  endtask

  task automatic drain();
    @(negedge clk_i) s_axis_tvalid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] a, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= v;
    @(negedge clk_i) penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (a == 0) sb.retry_limit = v[2:0];
  endtask

  // one transfer of up to nmsg messages; later messages get random content
  task automatic transfer(int nmsg, logic [9:0] addr, logic [7:0] flags, logic [7:0] len,
                          int prefill);
    int guard;
    for (int m = 0; m < nmsg; m++) begin
      if (m > 0) begin
        if (sb.ph != PH_WAITDESC) break;
        addr = $urandom; flags = $urandom; len = $urandom_range(0, 4);
        prefill = $urandom_range(0, 6);
      end
      send(FN_DESC, addr, flags, len, $urandom, $urandom, $urandom, m == nmsg - 1,
           $urandom);
      repeat (prefill) send_byte($urandom);
      guard = 0;
      while (sb.ph != PH_IDLE && sb.ph != PH_WAITDESC && guard < 20000) begin
        guard++;
        if (sb.ph == PH_DATDAT && sb.fifo_cnt == 0 && !sb.d_flags[FL_FILL])
          send_byte($urandom);
        else if ($urandom_range(0, 99) < 4)
          send(FN_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom);
        else if ($urandom_range(0, 99) < 3)
          send(FN_DESC, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom);
        else send_tick();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1;
    apb_write(3'd4, 32'h5);
    apb_write(3'd0, 32'd0);
    nack_pct = 100;
    transfer(1, 10'h2a, 8'h00, 8'd1, 0);
    transfer(1, 10'h3ff, 8'h13, 8'd2, 0);
    drain();
    apb_write(3'd0, 32'd7);
    transfer(1, 10'h000, 8'h01, 8'd1, 0);
    transfer(1, 10'h155, 8'h03, 8'd2, 0);
    drain();
    apb_write(3'd0, 32'd2);
    nack_pct = 0;
    transfer(1, 10'h3ff, 8'h03, 8'd3, 0);
    transfer(1, 10'h2aa, 8'h02, 8'd2, 2);
    transfer(1, 10'h07f, 8'h80, 8'd2, 2);
    transfer(1, 10'h001, 8'h40, 8'd2, 0);
    transfer(1, 10'h050, 8'h21, 8'd3, 0);
    transfer(1, 10'h050, 8'h08, 8'd1, 1);
    transfer(1, 10'h050, 8'h04, 8'd1, 1);
    transfer(1, 10'h050, 8'h00, 8'd0, 20);
    transfer(3, 10'h123, 8'h00, 8'd1, 1);
    gap_max = 0; stall_max = 0;
    transfer(1, 10'h3ff, 8'hff, 8'd2, 0);
    transfer(1, 10'h000, 8'h40, 8'd2, 0);
    nack_pct = 60;
    transfer(1, 10'h01a, 8'h90, 8'd3, 0);
    transfer(1, 10'h01a, 8'h10, 8'd3, 3);
    drain();
    while (items_sent < 750) begin
      if ($urandom_range(0, 7) == 0) begin
        drain();
        apb_write(3'd0, $urandom_range(0, 7));
      end
      case ($urandom_range(0, 3))
        0: begin gap_max = 0; stall_max = 0; end
        1: begin gap_max = 14; stall_max = 0; end
        2: begin gap_max = 0; stall_max = 14; end
        default: begin gap_max = 14; stall_max = 14; end
      endcase
      nack_pct = ($urandom_range(0, 4) == 0) ? 50 : 3;
      transfer($urandom_range(1, 3), $urandom, $urandom, $urandom_range(0, 4),
               $urandom_range(0, 6));
    end
    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/i2cme_pkg.sv
rtl/i2cme_fifo.sv
rtl/i2cme_core.sv
rtl/i2c_master_message_engine.sv
rtl/i2cme_checker.sv
tb/sv/tb_i2c_master_message_engine.sv
